// ===== hw/rtl/trdt_pkg.sv =====
`default_nettype none

package trdt_pkg;

  // Event kinds carried by the mode field
  typedef enum logic [1:0] {
    MODE_HUMIDITY = 2'd0,
    MODE_CO2      = 2'd1,
    MODE_TICK     = 2'd2,
    MODE_BUTTON   = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_P0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_P1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_P2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CO2_P0 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CO2_P1 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CO2_P2 = 3'd5;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned HUM_LIM_W  = 7;
  localparam int unsigned HUM_W      = 10;
  localparam int unsigned HUM_CMP_W  = 11;  // holds 10 * 127
  localparam int unsigned CO2_W      = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned DUR_W      = 17;  // up to 86400 seconds

  // Profile codes
  localparam logic [1:0] PROFILE_0 = 2'd0;
  localparam logic [1:0] PROFILE_1 = 2'd1;
  localparam logic [1:0] PROFILE_2 = 2'd2;
  localparam logic [1:0] PROFILE_BAD = 2'd3;

  // Reset thresholds
  localparam logic [HUM_LIM_W-1:0] HUM_RST_P0 = 7'd95;
  localparam logic [HUM_LIM_W-1:0] HUM_RST_P1 = 7'd95;
  localparam logic [HUM_LIM_W-1:0] HUM_RST_P2 = 7'd85;
  localparam logic [CO2_W-1:0]     CO2_RST    = 16'd1000;

  // Duty timer phase lengths in seconds
  localparam logic [DUR_W-1:0] FAN_ON_SECS   = 17'd1200;
  localparam logic [DUR_W-1:0] FAN_OFF_SECS  = 17'd3600;
  localparam logic [DUR_W-1:0] PUMP_ON_SECS  = 17'd2;
  localparam logic [DUR_W-1:0] PUMP_OFF_SECS = 17'd4;

  // Update applied to one relay channel by one transaction
  typedef struct packed {
    logic              sample_en;
    logic              forced_on;
    logic              tick_en;
    logic [TIME_W-1:0] now;
  } chan_op_t;

endpackage

`default_nettype wire

// ===== hw/rtl/trdt_cfg.sv =====
`default_nettype none

module trdt_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [trdt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [trdt_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic [1:0]                         profile_sel,
  output logic      [trdt_pkg::HUM_LIM_W-1:0]     hum_limit,
  output logic      [trdt_pkg::CO2_W-1:0]         co2_limit
);
  import trdt_pkg::*;

  logic [HUM_LIM_W-1:0] hum_p0, hum_p1, hum_p2;
  logic [CO2_W-1:0]     co2_p0, co2_p1, co2_p2;

  // Hold the threshold registers; writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      hum_p0 <= HUM_RST_P0;
      hum_p1 <= HUM_RST_P1;
      hum_p2 <= HUM_RST_P2;
      co2_p0 <= CO2_RST;
      co2_p1 <= CO2_RST;
      co2_p2 <= CO2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUM_P0: hum_p0 <= cfg_data[HUM_LIM_W-1:0];
        CFG_HUM_P1: hum_p1 <= cfg_data[HUM_LIM_W-1:0];
        CFG_HUM_P2: hum_p2 <= cfg_data[HUM_LIM_W-1:0];
        CFG_CO2_P0: co2_p0 <= cfg_data;
        CFG_CO2_P1: co2_p1 <= cfg_data;
        CFG_CO2_P2: co2_p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select the active profile's limits; the unused code falls back to profile 0
  always_comb begin
    case (profile_sel)
      PROFILE_1: begin
        hum_limit = hum_p1;
        co2_limit = co2_p1;
      end
      PROFILE_2: begin
        hum_limit = hum_p2;
        co2_limit = co2_p2;
      end
      default: begin
        hum_limit = hum_p0;
        co2_limit = co2_p0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/trdt_chan.sv =====
`default_nettype none

module trdt_chan (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire trdt_pkg::chan_op_t             op,
  input  wire logic [trdt_pkg::DUR_W-1:0]     on_secs,
  input  wire logic [trdt_pkg::DUR_W-1:0]     off_secs,
  output logic                                relay,
  output logic                                by_timer
);
  import trdt_pkg::*;

  logic              phase_on;
  logic [TIME_W-1:0] phase_start;

  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] dur;
  logic              expired;

  // Elapsed time wraps modulo 2^32
  assign elapsed = op.now - phase_start;
  assign dur     = phase_on ? TIME_W'(on_secs) : TIME_W'(off_secs);
  assign expired = elapsed > dur;

  // Force or release the relay on a sample; toggle the phase on an expired tick while timer-driven
  always_ff @(posedge clk) begin
    if (rst) begin
      relay       <= 1'b0;
      by_timer    <= 1'b1;
      phase_on    <= 1'b0;
      phase_start <= '0;
    end else if (op.sample_en) begin
      relay    <= op.forced_on;
      by_timer <= ~op.forced_on;
    end else if (op.tick_en && by_timer && expired) begin
      phase_on    <= ~phase_on;
      relay       <= ~phase_on;
      phase_start <= op.now;
    end
  end

  a_force_on: assert property (@(posedge clk) disable iff (rst)
    op.sample_en && op.forced_on |=> relay && !by_timer)
    else $error("channel not forced on by sample");

  a_release: assert property (@(posedge clk) disable iff (rst)
    op.sample_en && !op.forced_on |=> !relay && by_timer)
    else $error("channel not released to timer by sample");

  a_suspended_hold: assert property (@(posedge clk) disable iff (rst)
    !by_timer && !op.sample_en |=> $stable(phase_on) && $stable(phase_start) && $stable(relay))
    else $error("suspended timer moved");

  a_timer_relay: assert property (@(posedge clk) disable iff (rst)
    by_timer && op.tick_en && !op.sample_en && expired |=> relay == phase_on)
    else $error("relay does not follow timer phase");

endmodule

`default_nettype wire

// ===== hw/rtl/threshold_relay_with_duty_timer_unit.sv =====
// Channel  Handshake           Payload
// in       in_valid/in_ready   mode, humidity_tenths, co2_ppm, now_seconds, pin_level
// out      out_valid/out_ready pump_on, fan_on, profile, pump_timer_active, fan_timer_active
// cfg      cfg_we (no wait)    cfg_index, cfg_data
//
// One transaction per cycle while out_ready holds; each passes the input and result registers.
// The input register feeds the compare/subtract logic, which updates the channel state
// and loads the result register in the same edge.
// Synchronous active-high reset: profile 0, relays off, both timers active, reset limits.
// A stalled result holds the input register; a new transaction is taken as the result leaves.
`default_nettype none

module threshold_relay_with_duty_timer_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [1:0]                       mode,
  input  wire logic [trdt_pkg::HUM_W-1:0]       humidity_tenths,
  input  wire logic [trdt_pkg::CO2_W-1:0]       co2_ppm,
  input  wire logic [trdt_pkg::TIME_W-1:0]      now_seconds,
  input  wire logic                             pin_level,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic                                  pump_on,
  output logic                                  fan_on,
  output logic      [1:0]                       profile,
  output logic                                  pump_timer_active,
  output logic                                  fan_timer_active,
  input  wire logic                             cfg_we,
  input  wire logic [trdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [trdt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import trdt_pkg::*;

  // Input register
  logic              s1_valid;
  mode_t             s1_mode;
  logic [HUM_W-1:0]  s1_hum;
  logic [CO2_W-1:0]  s1_co2;
  logic [TIME_W-1:0] s1_now;
  logic              s1_pin;

  logic              advance;
  logic [1:0]        active_profile;
  logic [1:0]        active_profile_next;
  logic [HUM_LIM_W-1:0] hum_limit;
  logic [CO2_W-1:0]  co2_limit;
  logic [HUM_CMP_W-1:0] hum_thresh;
  chan_op_t          pump_op, fan_op;
  logic              pump_relay, fan_relay, pump_by_timer, fan_by_timer;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Capture a transaction into the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_mode <= mode_t'(mode);
      s1_hum  <= humidity_tenths;
      s1_co2  <= co2_ppm;
      s1_now  <= now_seconds;
      s1_pin  <= pin_level;
    end
  end

  trdt_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .profile_sel (active_profile),
    .hum_limit   (hum_limit),
    .co2_limit   (co2_limit)
  );

  // Scale the percent limit to tenths: 10x = 8x + 2x
  assign hum_thresh = {1'b0, hum_limit, 3'b000} + {3'b000, hum_limit, 1'b0};

  // Build the per-channel updates
  always_comb begin
    pump_op.sample_en = advance && (s1_mode == MODE_HUMIDITY);
    pump_op.forced_on = {1'b0, s1_hum} < hum_thresh;
    pump_op.tick_en   = advance && (s1_mode == MODE_TICK);
    pump_op.now       = s1_now;
    fan_op.sample_en  = advance && (s1_mode == MODE_CO2);
    fan_op.forced_on  = s1_co2 > co2_limit;
    fan_op.tick_en    = advance && (s1_mode == MODE_TICK);
    fan_op.now        = s1_now;
  end

  trdt_chan u_pump (
    .clk      (clk),
    .rst      (rst),
    .op       (pump_op),
    .on_secs  (PUMP_ON_SECS),
    .off_secs (PUMP_OFF_SECS),
    .relay    (pump_relay),
    .by_timer (pump_by_timer)
  );

  trdt_chan u_fan (
    .clk      (clk),
    .rst      (rst),
    .op       (fan_op),
    .on_secs  (FAN_ON_SECS),
    .off_secs (FAN_OFF_SECS),
    .relay    (fan_relay),
    .by_timer (fan_by_timer)
  );

  // Step the profile on a low button level, wrapping after profile 2
  always_comb begin
    active_profile_next = active_profile;
    if (advance && (s1_mode == MODE_BUTTON) && !s1_pin) begin
      case (active_profile)
        PROFILE_0: active_profile_next = PROFILE_1;
        PROFILE_1: active_profile_next = PROFILE_2;
        default:   active_profile_next = PROFILE_0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_profile <= PROFILE_0;
    end else begin
      active_profile <= active_profile_next;
    end
  end

  // Result register: post-update relay state of each channel
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pump_on           = pump_relay;
  assign fan_on            = fan_relay;
  assign profile           = active_profile;
  assign pump_timer_active = pump_by_timer;
  assign fan_timer_active  = fan_by_timer;

  a_profile_code: assert property (@(posedge clk) disable iff (rst)
    active_profile != PROFILE_BAD)
    else $error("profile holds unused code");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result lost after advance");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(active_profile) && $stable(pump_relay)
      && $stable(fan_relay))
    else $error("state moved under a stalled result");

endmodule

`default_nettype wire
